[hw/rtl/afa_pkg.sv]
package afa_pkg;

  localparam int unsigned FIELD_BITS  = 32;
  localparam int unsigned STATUS_BITS = 2;

  localparam logic [STATUS_BITS-1:0] STATUS_DONE  = 2'd0;
  localparam logic [STATUS_BITS-1:0] STATUS_NOFIT = 2'd1;
  localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd2;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [FIELD_BITS-1:0] POOL_RESET = 32'd65536;

  typedef enum logic [4:0] {
    S_INIT,
    S_IDLE,
    S_A_RD,
    S_A_LD,
    S_A_TST,
    S_A_WR,
    S_F_RD,
    S_F_LD,
    S_UP_RD,
    S_UP_WR,
    S_M0,
    S_M0_LD,
    S_M_RD,
    S_M_LD,
    S_DN_RD,
    S_DN_WR,
    S_DONE
  } st_t;

endpackage

[hw/rtl/afa_ram.sv]
module afa_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 17
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/aligned_first_fit_allocator.sv]
// Channel | Direction | Ports                       | Contents
// in      | slave     | in_tvalid/tready/tdata/tuser | tdata: req_size, align_bytes, free_offset
//         |           |                             | tuser: cmd
// out     | master    | out_tvalid/tready/tdata/tuser| tdata: granted_offset; tuser: status
// cfg     | slave     | cfg_valid/cfg_ready/cfg_data | pool_size
//
// One item is worked on at a time; the free list lives in a single memory with one
// write and one registered read port, and that port sets the pace. An allocate scans the
// entries until one fits and shifts later entries down when a block is used up. A free
// scans for the insert slot, shifts entries up to open it, sweeps the list for merges
// and shifts entries down for each merge or dropped block.
// After reset, and after each pool_size write, the head entry is rewritten before
// items are taken. A finished result waits in the output register while the next item
// is accepted; only a further result stalls until out_tready frees that register.
module aligned_first_fit_allocator
  import afa_pkg::*;
#(
  parameter int unsigned MAX_FREE_BLOCKS = 16,
  parameter int unsigned ADDR_BITS       = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // [31:0] req_size, [63:32] align_bytes, [95:64] free_offset
  input  logic        in_tuser,   // [0] cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] granted_offset
  output logic [1:0]  out_tuser,  // [1:0] status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data    // pool_size
);

  localparam int unsigned A     = ADDR_BITS;
  localparam int unsigned DEPTH = MAX_FREE_BLOCKS + 1;   // one spare slot for an insert
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(MAX_FREE_BLOCKS + 2);
  localparam int unsigned XW    = A + FIELD_BITS;

  localparam logic [A-1:0]  AMASK = {A{1'b1}};
  localparam logic [XW-1:0] XMASK = {{FIELD_BITS{1'b0}}, AMASK};

  // Saturate a field value at the top of the offset range.
  function automatic logic [A-1:0] sat_addr(input logic [FIELD_BITS-1:0] v);
    logic [XW-1:0] x;
    x = {{A{1'b0}}, v};
    return (x > XMASK) ? AMASK : x[A-1:0];
  endfunction

  // Keep the low offset bits of a field value.
  function automatic logic [A-1:0] low_addr(input logic [FIELD_BITS-1:0] v);
    logic [XW-1:0] x;
    x = {{A{1'b0}}, v};
    return x[A-1:0];
  endfunction

  st_t state_r, state_nxt, ret_r, ret_nxt;

  logic [FIELD_BITS-1:0]  pool_r, pool_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic [CW-1:0]          i_r, i_nxt;
  logic [CW-1:0]          k_r, k_nxt;
  logic [CW-1:0]          pos_r, pos_nxt;
  logic [A-1:0]           a_r, a_nxt;
  logic [A-1:0]           size_r, size_nxt;
  logic [A-1:0]           off_r, off_nxt;
  logic [A-1:0]           s_r, s_nxt;
  logic [A-1:0]           l_r, l_nxt;
  logic [A-1:0]           pad_r, pad_nxt;
  logic [A-1:0]           lp_r, lp_nxt;
  logic [A-1:0]           cur_s_r, cur_s_nxt;
  logic [A-1:0]           cur_l_r, cur_l_nxt;
  logic [A-1:0]           grant_r, grant_nxt;
  logic [STATUS_BITS-1:0] status_r, status_nxt;
  logic                   ov_r, ov_nxt;
  logic [31:0]            od_r, od_nxt;
  logic [1:0]             ou_r, ou_nxt;

  logic           we;
  logic [AW-1:0]  waddr, raddr;
  logic [2*A-1:0] wdata, rdata;
  logic [A-1:0]   rd_s, rd_l;

  logic [A-1:0] pool_len, in_req_sat, in_off, in_room, in_free_size;
  logic [A-1:0] in_align, in_align_low;
  logic [A-1:0] rem, aligned, left, lp;
  logic         fit, touch, in_acc, cfg_acc, out_free;

  assign rd_s = rdata[2*A-1:A];
  assign rd_l = rdata[A-1:0];

  afa_ram #(
    .WIDTH (2 * A),
    .DEPTH (DEPTH)
  ) u_list (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign in_tready = (state_r == S_IDLE) && !cfg_valid;
  assign cfg_ready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign out_free  = !ov_r || out_tready;

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tuser  = ou_r;

  // Field decoding at the input.
  always_comb begin
    pool_len     = sat_addr(pool_r);
    in_req_sat   = sat_addr(in_tdata[31:0]);
    in_off       = low_addr(in_tdata[95:64]);
    in_room      = AMASK - in_off;
    in_free_size = (low_addr(in_tdata[31:0]) > in_room || in_req_sat > in_room) ?
                   in_room : in_req_sat;
    in_align     = low_addr(in_tdata[63:32]);
    in_align_low = in_align & (~in_align + A'(1));
    if (in_align_low == '0) begin
      in_align_low = A'(1);
    end
  end

  // Shared arithmetic for the scan, the carve and the merge test.
  always_comb begin
    rem     = rd_s & (a_r - A'(1));
    lp      = l_r - pad_r;
    fit     = (pad_r <= l_r) && (size_r <= lp);
    aligned = s_r + pad_r;
    left    = lp_r - size_r;
    touch   = (rd_s >= cur_s_r) && ((rd_s - cur_s_r) == cur_l_r);
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_INIT: state_nxt = S_IDLE;
      S_IDLE: begin
        if (cfg_acc) begin
          state_nxt = S_INIT;
        end else if (in_acc) begin
          if (in_tuser == CMD_ALLOC) begin
            state_nxt = S_A_RD;
          end else if (in_free_size == '0) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_F_RD;
          end
        end
      end
      S_A_RD:  state_nxt = (i_r < cnt_r) ? S_A_LD : S_DONE;
      S_A_LD:  state_nxt = S_A_TST;
      S_A_TST: state_nxt = fit ? S_A_WR : S_A_RD;
      S_A_WR:  state_nxt = (left != '0) ? S_DONE : S_DN_RD;
      S_F_RD:  state_nxt = (pos_r < cnt_r) ? S_F_LD : S_UP_RD;
      S_F_LD:  state_nxt = (rd_s <= off_r) ? S_F_RD : S_UP_RD;
      S_UP_RD: state_nxt = (k_r > pos_r) ? S_UP_WR : S_M0;
      S_UP_WR: state_nxt = S_UP_RD;
      S_M0:    state_nxt = S_M0_LD;
      S_M0_LD: state_nxt = S_M_RD;
      S_M_RD: begin
        if (i_r + CW'(1) < cnt_r) begin
          state_nxt = S_M_LD;
        end else if (cnt_r > CW'(MAX_FREE_BLOCKS)) begin
          state_nxt = S_DN_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_M_LD:  state_nxt = touch ? S_DN_RD : S_M_RD;
      S_DN_RD: state_nxt = (k_r + CW'(1) < cnt_r) ? S_DN_WR : ret_r;
      S_DN_WR: state_nxt = S_DN_RD;
      S_DONE:  state_nxt = out_free ? S_IDLE : S_DONE;
      default: state_nxt = S_INIT;
    endcase
  end

  // Memory port control.
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = rdata;
    raddr = '0;
    unique case (state_r)
      S_INIT: begin
        we    = 1'b1;
        wdata = {{A{1'b0}}, pool_len};
      end
      S_A_RD:  raddr = i_r[AW-1:0];
      S_A_WR: begin
        we    = (left != '0);
        waddr = i_r[AW-1:0];
        wdata = {aligned + size_r, left};
      end
      S_F_RD:  raddr = pos_r[AW-1:0];
      S_UP_RD: begin
        if (k_r > pos_r) begin
          raddr = k_r[AW-1:0] - AW'(1);
        end else begin
          we    = 1'b1;
          waddr = pos_r[AW-1:0];
          wdata = {off_r, size_r};
        end
      end
      S_UP_WR: begin
        we    = 1'b1;
        waddr = k_r[AW-1:0];
      end
      S_M0:    raddr = '0;
      S_M_RD:  raddr = i_r[AW-1:0] + AW'(1);
      S_M_LD: begin
        we    = touch;
        waddr = i_r[AW-1:0];
        wdata = {cur_s_r, cur_l_r + rd_l};
      end
      S_DN_RD: raddr = k_r[AW-1:0] + AW'(1);
      S_DN_WR: begin
        we    = 1'b1;
        waddr = k_r[AW-1:0];
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // Datapath and bookkeeping registers.
  always_comb begin
    pool_nxt   = pool_r;
    cnt_nxt    = cnt_r;
    i_nxt      = i_r;
    k_nxt      = k_r;
    pos_nxt    = pos_r;
    ret_nxt    = ret_r;
    a_nxt      = a_r;
    size_nxt   = size_r;
    off_nxt    = off_r;
    s_nxt      = s_r;
    l_nxt      = l_r;
    pad_nxt    = pad_r;
    lp_nxt     = lp_r;
    cur_s_nxt  = cur_s_r;
    cur_l_nxt  = cur_l_r;
    grant_nxt  = grant_r;
    status_nxt = status_r;
    ov_nxt     = ov_r && !out_tready;
    od_nxt     = od_r;
    ou_nxt     = ou_r;
    unique case (state_r)
      S_INIT: cnt_nxt = (pool_len != '0) ? CW'(1) : '0;
      S_IDLE: begin
        if (cfg_acc) begin
          pool_nxt = cfg_data;
        end else if (in_acc) begin
          a_nxt      = in_align_low;
          off_nxt    = in_off;
          size_nxt   = (in_tuser == CMD_ALLOC) ? in_req_sat : in_free_size;
          i_nxt      = '0;
          pos_nxt    = '0;
          grant_nxt  = '0;
          status_nxt = STATUS_DONE;
        end
      end
      S_A_RD: begin
        if (i_r >= cnt_r) begin
          status_nxt = STATUS_NOFIT;
          grant_nxt  = '0;
        end
      end
      S_A_LD: begin
        s_nxt   = rd_s;
        l_nxt   = rd_l;
        pad_nxt = (rem == '0) ? '0 : a_r - rem;
      end
      S_A_TST: begin
        lp_nxt = lp;
        if (!fit) begin
          i_nxt = i_r + CW'(1);
        end
      end
      S_A_WR: begin
        grant_nxt = aligned;
        k_nxt     = i_r;
        ret_nxt   = S_DONE;
      end
      S_F_RD: begin
        if (pos_r >= cnt_r) begin
          k_nxt = cnt_r;
        end
      end
      S_F_LD: begin
        if (rd_s <= off_r) begin
          pos_nxt = pos_r + CW'(1);
        end else begin
          k_nxt = cnt_r;
        end
      end
      S_UP_RD: begin
        if (k_r <= pos_r) begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      S_UP_WR: k_nxt = k_r - CW'(1);
      S_M0:    i_nxt = '0;
      S_M0_LD: begin
        cur_s_nxt = rd_s;
        cur_l_nxt = rd_l;
      end
      S_M_RD: begin
        if (!(i_r + CW'(1) < cnt_r) && cnt_r > CW'(MAX_FREE_BLOCKS)) begin
          // No merge took place, so the new block still sits at its insert slot.
          k_nxt      = pos_r;
          ret_nxt    = S_DONE;
          status_nxt = STATUS_FULL;
        end
      end
      S_M_LD: begin
        if (touch) begin
          cur_l_nxt = cur_l_r + rd_l;
          k_nxt     = i_r + CW'(1);
          ret_nxt   = S_M_RD;
        end else begin
          cur_s_nxt = rd_s;
          cur_l_nxt = rd_l;
          i_nxt     = i_r + CW'(1);
        end
      end
      S_DN_RD: begin
        if (!(k_r + CW'(1) < cnt_r) && cnt_r != '0) begin
          cnt_nxt = cnt_r - CW'(1);
        end
      end
      S_DN_WR: k_nxt = k_r + CW'(1);
      S_DONE: begin
        if (out_free) begin
          ov_nxt = 1'b1;
          od_nxt = 32'(grant_r);
          ou_nxt = status_r;
        end
      end
      default: begin
        cnt_nxt = cnt_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      ret_r   <= S_DONE;
      pool_r  <= POOL_RESET;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      pool_r  <= pool_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r      <= i_nxt;
    k_r      <= k_nxt;
    pos_r    <= pos_nxt;
    a_r      <= a_nxt;
    size_r   <= size_nxt;
    off_r    <= off_nxt;
    s_r      <= s_nxt;
    l_r      <= l_nxt;
    pad_r    <= pad_nxt;
    lp_r     <= lp_nxt;
    cur_s_r  <= cur_s_nxt;
    cur_l_r  <= cur_l_nxt;
    grant_r  <= grant_nxt;
    status_r <= status_nxt;
    od_r     <= od_nxt;
    ou_r     <= ou_nxt;
  end

endmodule
